### sv/midpoint_ellipse_stepper_core_defines.svh
// assertion macros shared by the ellipse stepper rtl
`ifndef MIDPOINT_ELLIPSE_STEPPER_CORE_DEFINES_SVH
`define MIDPOINT_ELLIPSE_STEPPER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define MES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// consequent checked in the cycle after the antecedent
`define MES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MES_ASSERT(label, prop, msg)
`define MES_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### sv/mes_pkg.sv
// shared types and constants of the midpoint ellipse stepper
package mes_pkg;

  localparam int unsigned COORD_BITS_DEF  = 11;
  localparam int unsigned RADIUS_BITS_DEF = 10;
  localparam int unsigned COLOR_BITS      = 24;

  localparam int unsigned K_FOUR   = 4;
  localparam int unsigned K_TWELVE = 12;
  localparam int unsigned K_EIGHT  = 8;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_REG1 = 2'd1,
    PH_REG2 = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    MUL_SQ_A  = 2'd0,
    MUL_SQ_B  = 2'd1,
    MUL_CROSS = 2'd2
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_e mul_op;
    logic    setup;
    logic    step;
    logic    sel_r2;
    logic    emit;
    logic    emit_r2;
    logic    emit_fin;
  } mes_cmd_t;

  typedef struct packed {
    logic go_one;
    logic go_two;
  } mes_status_t;

endpackage

### sv/midpoint_ellipse_stepper_core.sv
// midpoint ellipse stepper top level
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid_i/in_ready_o  | command, center_x/y, radius_x/y, pixel_color
//  out     | out_valid_o/out_ready_i| px_right/left, py_down/up, out_color, flags
//
// load: three products on the one shared multiplier, then term set-up
// advance in region one: step, emit; region one exit: cross, set-up, test, emit
// region two: step, test, emit; advance while idle or finished: no item out
// one item in flight; the result register lets the next item start while it waits
// reset: rst_ni asynchronous, active low, leaves the block idle with no ellipse
`include "midpoint_ellipse_stepper_core_defines.svh"
module midpoint_ellipse_stepper_core #(
  parameter int unsigned COORD_BITS  = mes_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = mes_pkg::RADIUS_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [COORD_BITS-1:0]          center_x_i,
  input  logic [COORD_BITS-1:0]          center_y_i,
  input  logic [RADIUS_BITS-1:0]         radius_x_i,
  input  logic [RADIUS_BITS-1:0]         radius_y_i,
  input  logic [mes_pkg::COLOR_BITS-1:0] pixel_color_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [COORD_BITS+1:0]   px_right_o,
  output logic signed [COORD_BITS+1:0]   px_left_o,
  output logic signed [COORD_BITS+1:0]   py_down_o,
  output logic signed [COORD_BITS+1:0]   py_up_o,
  output logic [mes_pkg::COLOR_BITS-1:0] out_color_o,
  output logic                           in_region_two_o,
  output logic                           finished_o
);
  import mes_pkg::*;

  mes_cmd_t    cmd;
  mes_status_t status;
  command_e    command;

  assign command = command_e'(command_i);

  mes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mes_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .radius_x_i      (radius_x_i),
    .radius_y_i      (radius_y_i),
    .pixel_color_i   (pixel_color_i),
    .px_right_o      (px_right_o),
    .px_left_o       (px_left_o),
    .py_down_o       (py_down_o),
    .py_up_o         (py_up_o),
    .out_color_o     (out_color_o),
    .in_region_two_o (in_region_two_o),
    .finished_o      (finished_o)
  );

  `MES_ASSERT(a_finish_in_region_two, out_valid_o && finished_o |-> in_region_two_o, "finished item outside region two")

endmodule

### sv/mes_datapath.sv
// ellipse stepper datapath: shared multiplier, decision terms, point registers
`include "midpoint_ellipse_stepper_core_defines.svh"
module mes_datapath #(
  parameter int unsigned COORD_BITS  = mes_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = mes_pkg::RADIUS_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mes_pkg::mes_cmd_t                cmd_i,
  output mes_pkg::mes_status_t             status_o,
  input  logic [COORD_BITS-1:0]            center_x_i,
  input  logic [COORD_BITS-1:0]            center_y_i,
  input  logic [RADIUS_BITS-1:0]           radius_x_i,
  input  logic [RADIUS_BITS-1:0]           radius_y_i,
  input  logic [mes_pkg::COLOR_BITS-1:0]   pixel_color_i,
  output logic signed [COORD_BITS+1:0]     px_right_o,
  output logic signed [COORD_BITS+1:0]     px_left_o,
  output logic signed [COORD_BITS+1:0]     py_down_o,
  output logic signed [COORD_BITS+1:0]     py_up_o,
  output logic [mes_pkg::COLOR_BITS-1:0]   out_color_o,
  output logic                             in_region_two_o,
  output logic                             finished_o
);
  import mes_pkg::*;

  localparam int unsigned CurW  = RADIUS_BITS + 1;
  localparam int unsigned SqW   = 2 * RADIUS_BITS;
  localparam int unsigned ProdW = 3 * RADIUS_BITS;
  localparam int unsigned TestW = 3 * RADIUS_BITS + 1;
  localparam int unsigned DecW  = 4 * RADIUS_BITS + 4;
  localparam int unsigned OutW  = COORD_BITS + 2;
  localparam int unsigned SumW  = COORD_BITS + RADIUS_BITS + 3;

  localparam logic signed [DecW-1:0] KFour   = DecW'(K_FOUR);
  localparam logic signed [DecW-1:0] KTwelve = DecW'(K_TWELVE);
  localparam logic signed [DecW-1:0] KEight  = DecW'(K_EIGHT);

  logic [COORD_BITS-1:0]  ctr_x_q, ctr_y_q;
  logic [RADIUS_BITS-1:0] semi_a_q, semi_b_q;
  logic [COLOR_BITS-1:0]  color_q;
  logic [CurW-1:0]        cur_x_q, cur_y_q;
  logic [SqW-1:0]         aa_q, bb_q;
  logic [ProdW-1:0]       qpp_q;
  logic [TestW-1:0]       tx_q, ty_q;
  logic signed [DecW-1:0] dec_q, st1_q, st2_q, dl1_q, dl2_q;

  logic signed [OutW-1:0] px_right_q, px_left_q, py_down_q, py_up_q;
  logic [COLOR_BITS-1:0]  out_color_q;
  logic                   r2_q, fin_q;

  // shared multiplier
  logic [RADIUS_BITS-1:0] mul_a;
  logic [SqW-1:0]         mul_b;
  logic [ProdW-1:0]       mul_p;

  always_comb begin
    case (cmd_i.mul_op)
      MUL_SQ_A: begin
        mul_a = semi_a_q;
        mul_b = SqW'(semi_a_q);
      end
      MUL_SQ_B: begin
        mul_a = semi_b_q;
        mul_b = SqW'(semi_b_q);
      end
      MUL_CROSS: begin
        // q times p squared: b*a*a for region one, a*b*b for region two
        mul_a = cmd_i.sel_r2 ? semi_a_q : semi_b_q;
        mul_b = cmd_i.sel_r2 ? bb_q : aa_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  // region set-up terms
  logic [SqW-1:0]         pp, qq;
  logic signed [DecW-1:0] pp_s, qq_s, qpp_s;
  logic signed [DecW-1:0] dec_init_d, st1_init_d, st2_init_d, dl1_init_d, dl2_init_d;

  assign pp    = cmd_i.sel_r2 ? bb_q : aa_q;
  assign qq    = cmd_i.sel_r2 ? aa_q : bb_q;
  assign pp_s  = DecW'(pp);
  assign qq_s  = DecW'(qq);
  assign qpp_s = DecW'(qpp_q);

  assign dec_init_d = KFour * qq_s - KFour * qpp_s + pp_s;
  assign st1_init_d = KTwelve * qq_s;
  assign st2_init_d = KTwelve * qq_s + KEight * pp_s - KEight * qpp_s;
  assign dl1_init_d = KEight * qq_s;
  assign dl2_init_d = KEight * qq_s + KEight * pp_s;

  // incremental step
  logic                   stepped;
  logic signed [DecW-1:0] dec_step_d, st1_step_d, st2_step_d;
  logic [TestW-1:0]       aa_t, bb_t;

  assign stepped    = !dec_q[DecW-1];
  assign dec_step_d = stepped ? dec_q + st2_q : dec_q + st1_q;
  assign st2_step_d = stepped ? st2_q + dl2_q : st2_q + dl1_q;
  assign st1_step_d = st1_q + dl1_q;
  assign aa_t       = TestW'(aa_q);
  assign bb_t       = TestW'(bb_q);

  // region tests kept as running products y*a*a and x*b*b
  assign status_o.go_one = ty_q > tx_q;
  assign status_o.go_two = tx_q > ty_q;

  // point sums
  logic [SumW-1:0] right_sum, left_sum, down_sum, up_sum;

  assign right_sum = SumW'(ctr_x_q) + SumW'(cur_x_q);
  assign left_sum  = SumW'(ctr_x_q) - SumW'(cur_x_q);
  assign down_sum  = SumW'(ctr_y_q) + SumW'(cur_y_q);
  assign up_sum    = SumW'(ctr_y_q) - SumW'(cur_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q  <= '0;
      ctr_y_q  <= '0;
      semi_a_q <= '0;
      semi_b_q <= '0;
      color_q  <= '0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      aa_q     <= '0;
      bb_q     <= '0;
      qpp_q    <= '0;
      tx_q     <= '0;
      ty_q     <= '0;
      dec_q    <= '0;
      st1_q    <= '0;
      st2_q    <= '0;
      dl1_q    <= '0;
      dl2_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        ctr_x_q  <= center_x_i;
        ctr_y_q  <= center_y_i;
        semi_a_q <= radius_x_i;
        semi_b_q <= radius_y_i;
        color_q  <= pixel_color_i;
      end
      if (cmd_i.mul_en) begin
        case (cmd_i.mul_op)
          MUL_SQ_A:  aa_q  <= mul_p[SqW-1:0];
          MUL_SQ_B:  bb_q  <= mul_p[SqW-1:0];
          MUL_CROSS: qpp_q <= mul_p;
          default:   ;
        endcase
      end
      if (cmd_i.setup) begin
        dec_q <= dec_init_d;
        st1_q <= st1_init_d;
        st2_q <= st2_init_d;
        dl1_q <= dl1_init_d;
        dl2_q <= dl2_init_d;
        if (cmd_i.sel_r2) begin
          cur_x_q <= CurW'(semi_a_q);
          cur_y_q <= '0;
          tx_q    <= TestW'(qpp_q);
          ty_q    <= '0;
        end else begin
          cur_x_q <= '0;
          cur_y_q <= CurW'(semi_b_q);
          tx_q    <= '0;
          ty_q    <= TestW'(qpp_q);
        end
      end
      if (cmd_i.step) begin
        dec_q <= dec_step_d;
        st1_q <= st1_step_d;
        st2_q <= st2_step_d;
        if (cmd_i.sel_r2) begin
          cur_y_q <= cur_y_q + 1'b1;
          ty_q    <= ty_q + aa_t;
          if (stepped) begin
            cur_x_q <= cur_x_q - 1'b1;
            tx_q    <= tx_q - bb_t;
          end
        end else begin
          cur_x_q <= cur_x_q + 1'b1;
          tx_q    <= tx_q + bb_t;
          if (stepped) begin
            cur_y_q <= cur_y_q - 1'b1;
            ty_q    <= ty_q - aa_t;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      px_right_q  <= right_sum[OutW-1:0];
      px_left_q   <= left_sum[OutW-1:0];
      py_down_q   <= down_sum[OutW-1:0];
      py_up_q     <= up_sum[OutW-1:0];
      out_color_q <= color_q;
      r2_q        <= cmd_i.emit_r2;
      fin_q       <= cmd_i.emit_fin;
    end
  end

  assign px_right_o      = px_right_q;
  assign px_left_o       = px_left_q;
  assign py_down_o       = py_down_q;
  assign py_up_o         = py_up_q;
  assign out_color_o     = out_color_q;
  assign in_region_two_o = r2_q;
  assign finished_o      = fin_q;

  `MES_ASSERT_NEXT(a_r1_step_moves_x, cmd_i.step && !cmd_i.sel_r2, cur_x_q == $past(cur_x_q) + 1'b1, "region one step did not advance x")

endmodule

### sv/mes_ctrl.sv
// ellipse stepper controller: sequencing, phase and result handshake
`include "midpoint_ellipse_stepper_core_defines.svh"
module mes_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mes_pkg::command_e    command_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mes_pkg::mes_status_t status_i,
  output mes_pkg::mes_cmd_t    cmd_o
);
  import mes_pkg::*;

  typedef enum logic [7:0] {
    S_READY = 8'b0000_0001,
    S_SQ_A  = 8'b0000_0010,
    S_SQ_B  = 8'b0000_0100,
    S_CROSS = 8'b0000_1000,
    S_SETUP = 8'b0001_0000,
    S_STEP  = 8'b0010_0000,
    S_EVAL  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e   state_q, state_d;
  phase_e   phase_q, phase_d;
  logic     out_valid_q, out_valid_d;
  mes_cmd_t cmd;
  logic     in_ready;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    in_ready    = (state_q == S_READY);
    cmd          = '0;
    cmd.mul_op   = MUL_SQ_A;
    cmd.sel_r2   = (phase_q != PH_REG1);
    cmd.emit_r2  = (phase_q != PH_REG1);
    cmd.emit_fin = (phase_q == PH_DONE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_READY: begin
        if (in_valid_i) begin
          if (command_i == CMD_LOAD) begin
            cmd.load = 1'b1;
            phase_d  = PH_REG1;
            state_d  = S_SQ_A;
          end else begin
            case (phase_q)
              PH_REG1: begin
                if (status_i.go_one) begin
                  state_d = S_STEP;
                end else begin
                  // region one over: set up region two
                  phase_d = PH_REG2;
                  state_d = S_CROSS;
                end
              end
              PH_REG2: state_d = S_STEP;
              default: ;  // idle or done: item gives nothing
            endcase
          end
        end
      end
      S_SQ_A: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SQ_A;
        state_d    = S_SQ_B;
      end
      S_SQ_B: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SQ_B;
        state_d    = S_CROSS;
      end
      S_CROSS: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_CROSS;
        state_d    = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_d   = (phase_q == PH_REG1) ? S_EMIT : S_EVAL;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        state_d  = (phase_q == PH_REG1) ? S_EMIT : S_EVAL;
      end
      S_EVAL: begin
        if (!status_i.go_two) begin
          phase_d = PH_DONE;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.emit    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_READY;
        end
      end
      default: state_d = S_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_READY;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `MES_ASSERT_NEXT(a_load_starts_region_one, in_valid_i && in_ready_o && command_i == CMD_LOAD, phase_q == PH_REG1 && state_q == S_SQ_A, "load did not start region one")
  `MES_ASSERT_NEXT(a_idle_advance_dropped, in_valid_i && in_ready_o && command_i == CMD_ADVANCE && (phase_q == PH_IDLE || phase_q == PH_DONE), state_q == S_READY && phase_q == $past(phase_q), "advance without an ellipse changed state")

endmodule
